// ----- src/mhq_pkg.sv -----
// package: constants, widths and payload types of the hysteresis quantiser
package mhq_pkg;

	localparam int LEVELS       = 4;
	localparam int SCALE        = 10;
	localparam int FULL_PERCENT = 100;
	localparam int BAND_B       = 500 / LEVELS;
	localparam int STEP_M       = 1000 / LEVELS;
	localparam int HYST_RESET   = 25;
	localparam int LEVEL_MAX    = (LEVELS > 7) ? 7 : LEVELS;

	localparam int PCT_W   = 7;
	localparam int HYST_W  = 7;
	localparam int LEVEL_W = 3;
	localparam int Y_W     = 10;
	localparam int NUM_W   = 12;
	localparam int COUNT_W = $clog2(LEVELS + 1);

	typedef logic [PCT_W-1:0]          pct_t;
	typedef logic [HYST_W-1:0]         hyst_t;
	typedef logic [LEVEL_W-1:0]        level_t;
	typedef logic [Y_W-1:0]            scaled_t;
	typedef logic signed [NUM_W-1:0]   num_t;
	typedef logic [COUNT_W-1:0]        count_t;

endpackage

// ----- src/mhq_cfg_if.sv -----
// interface: configuration write channel carrying the hysteresis half-width
interface mhq_cfg_if;
	logic          valid;
	logic          ready;
	mhq_pkg::hyst_t hyst_width;

	modport source (output valid, output hyst_width, input ready);
	modport sink (input valid, input hyst_width, output ready);
endinterface

// ----- src/mhq_sample_if.sv -----
// interface: sample request channel carrying the percent sample
interface mhq_sample_if;
	logic          valid;
	logic          ready;
	mhq_pkg::pct_t sample_percent;

	modport source (output valid, output sample_percent, input ready);
	modport sink (input valid, input sample_percent, output ready);
endinterface

// ----- src/mhq_level_if.sv -----
// interface: result channel carrying the quantised level
interface mhq_level_if;
	logic            valid;
	logic            ready;
	mhq_pkg::level_t level;

	modport source (output valid, output level, input ready);
	modport sink (input valid, input level, output ready);
endinterface

// ----- src/multilevel_hysteresis_quantizer.sv -----
// top level: multi-level quantiser with hysteresis bands around each midpoint
// path: input register, one pass of band compares, result register, then the result channel
// throughput: one sample per cycle unless a stalled result holds the input register
// the previous sample and level are held in registers updated as each result is loaded
// reset (arst_n low, asynchronous): channels empty, hyst_width 25, stored sample and level 0
module multilevel_hysteresis_quantizer (
	input  logic         clk,
	input  logic         arst_n,
	mhq_cfg_if.sink      cfg,
	mhq_sample_if.sink   sample,
	mhq_level_if.source  result
);

	logic              valid_s1;
	mhq_pkg::pct_t     pct_s1;
	mhq_pkg::hyst_t    hyst_q;
	mhq_pkg::scaled_t  last_y_q;
	mhq_pkg::level_t   last_level_q;
	logic              result_valid_q;
	mhq_pkg::level_t   result_level_q;

	logic              s1_adv;
	mhq_pkg::pct_t     pct_c;
	mhq_pkg::scaled_t  pct_ext;
	mhq_pkg::scaled_t  y;
	mhq_pkg::num_t     y_n;
	mhq_pkg::num_t     h_n;
	mhq_pkg::num_t     prev_n;
	mhq_pkg::num_t     b_n;
	logic              found;
	logic              prev_in;
	mhq_pkg::level_t   lvl_plain;
	mhq_pkg::level_t   lvl_up;
	mhq_pkg::level_t   lvl_down;
	mhq_pkg::level_t   lvl_next;

	function automatic mhq_pkg::level_t level_of(input mhq_pkg::num_t num);
		mhq_pkg::count_t cnt;
		cnt = '0;
		for (int j = 1; j <= mhq_pkg::LEVELS; j++) begin
			if (num >= mhq_pkg::num_t'(j * mhq_pkg::STEP_M)) begin
				cnt = mhq_pkg::count_t'(j);
			end
		end
		return mhq_pkg::level_t'(cnt);
	endfunction

	assign s1_adv       = valid_s1 && (!result_valid_q || result.ready);
	assign sample.ready = !valid_s1 || s1_adv;
	assign cfg.ready    = 1'b1;
	assign result.valid = result_valid_q;
	assign result.level = result_level_q;

	// clamp and scale by ten
	assign pct_c   = (pct_s1 > mhq_pkg::pct_t'(mhq_pkg::FULL_PERCENT)) ?
	                 mhq_pkg::pct_t'(mhq_pkg::FULL_PERCENT) : pct_s1;
	assign pct_ext = mhq_pkg::scaled_t'(pct_c);
	assign y       = (pct_ext << 3) + (pct_ext << 1);

	assign y_n    = mhq_pkg::num_t'(y);
	assign h_n    = mhq_pkg::num_t'(hyst_q);
	assign prev_n = mhq_pkg::num_t'(last_y_q);
	assign b_n    = mhq_pkg::num_t'(mhq_pkg::BAND_B);

	assign lvl_plain = level_of(y_n + b_n);
	assign lvl_up    = level_of(y_n - h_n + b_n);
	assign lvl_down  = level_of(y_n + h_n + b_n);

	// lowest band holding the new sample wins
	always_comb begin
		mhq_pkg::num_t mid;
		found   = 1'b0;
		prev_in = 1'b0;
		mid     = '0;
		for (int k = 0; k < mhq_pkg::LEVELS; k++) begin
			mid = mhq_pkg::num_t'((2 * k + 1) * mhq_pkg::BAND_B);
			if (!found && (y_n > mid - h_n) && (y_n < mid + h_n)) begin
				found   = 1'b1;
				prev_in = (prev_n > mid - h_n) && (prev_n < mid + h_n);
			end
		end
	end

	always_comb begin
		if (!found) begin
			lvl_next = lvl_plain;
		end else if (prev_in) begin
			lvl_next = last_level_q;
		end else if (last_y_q < y) begin
			lvl_next = lvl_up;
		end else if (last_y_q > y) begin
			lvl_next = lvl_down;
		end else begin
			lvl_next = last_level_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hyst_q <= mhq_pkg::hyst_t'(mhq_pkg::HYST_RESET);
		end else if (cfg.valid && cfg.ready) begin
			hyst_q <= cfg.hyst_width;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			pct_s1 <= sample.sample_percent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
			last_y_q       <= '0;
			last_level_q   <= '0;
		end else begin
			if (!result_valid_q || result.ready) begin
				result_valid_q <= valid_s1;
			end
			if (s1_adv) begin
				last_y_q     <= y;
				last_level_q <= lvl_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			result_level_q <= lvl_next;
		end
	end

endmodule

// ----- src/mhq_checker.sv -----
// checker: port-level properties of the hysteresis quantiser, bound to the top level
module mhq_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            sample_valid,
	input logic            sample_ready,
	input logic            result_valid,
	input logic            result_ready,
	input mhq_pkg::level_t result_level
);

	logic sample_acc;
	logic result_stall;

	assign sample_acc   = sample_valid && sample_ready;
	assign result_stall = result_valid && !result_ready;

	// level never exceeds the top level
	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result_level <= mhq_pkg::level_t'(mhq_pkg::LEVEL_MAX)))
		else $error("level above range");

	// held result stays put
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_stall |=> (result_valid && $stable(result_level)))
		else $error("stalled result changed");

	// every accepted request reaches the output through the input register and the result register
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		sample_acc |=> ##1 result_valid)
		else $error("result missing after request");

	// one request buffered behind a stalled result fills the pipe
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		(sample_acc && result_stall) ##1 result_stall |-> !sample_ready)
		else $error("request taken with pipe full");

endmodule

bind multilevel_hysteresis_quantizer mhq_checker u_mhq_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.sample_valid (sample.valid),
	.sample_ready (sample.ready),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.result_level (result.level)
);
